@@ rtl/core/sdftw_pkg.sv @@
// ----------------------------------------------------------------------------
// sdftw_pkg: shared types and constants for the twist/bend point warp
// Fixed-point formats, the CORDIC datapath word, the arctangent table and
// the configuration register indexes.
// ----------------------------------------------------------------------------
package sdftw_pkg;

  // Width of every coordinate field on the ports
  localparam int FIELD_W = 32;

  // Guard bits carried below the Q16.16 point through the rotation
  localparam int GUARD_BITS = 8;

  // Shift that takes the gain product (Q16.16 * Q0.32) down to Q.24
  localparam int PRE_SHIFT = 32 - GUARD_BITS;

  // Lowest product bit of the phase: Q24.40 turns down to a Q0.32 fraction
  localparam int PHASE_LSB = 8;

  // Rotation datapath: x and y with guard bits and CORDIC growth headroom
  localparam int XY_W = 44;

  // Residual angle: 32-bit turn fraction plus sign and headroom
  localparam int Z_W = 34;

  // Reciprocal of the CORDIC gain, infinite-step limit, as an unsigned Q0.32
  localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WARP_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_TURNS = 2'd1;

  // Point in flight through the rotation chain
  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
    logic        [FIELD_W-1:0] pz;
  } cell_t;

  // Arctangent of 2^-i in units of 2^-32 turn; zero from step 31 on
  function automatic logic [31:0] atan_turns(input int step);
    logic [31:0] a;
    case (step)
      0:  a = 32'h2000_0000;
      1:  a = 32'h12E4_051E;
      2:  a = 32'h09FB_385B;
      3:  a = 32'h0511_11D4;
      4:  a = 32'h028B_0D43;
      5:  a = 32'h0145_D7E1;
      6:  a = 32'h00A2_F61E;
      7:  a = 32'h0051_7C55;
      8:  a = 32'h0028_BE53;
      9:  a = 32'h0014_5F2F;
      10: a = 32'h000A_2F98;
      11: a = 32'h0005_17CC;
      12: a = 32'h0002_8BE6;
      13: a = 32'h0001_45F3;
      14: a = 32'h0000_A2FA;
      15: a = 32'h0000_517D;
      16: a = 32'h0000_28BE;
      17: a = 32'h0000_145F;
      18: a = 32'h0000_0A30;
      19: a = 32'h0000_0518;
      20: a = 32'h0000_028C;
      21: a = 32'h0000_0146;
      22: a = 32'h0000_00A3;
      23: a = 32'h0000_0051;
      24: a = 32'h0000_0029;
      25: a = 32'h0000_0014;
      26: a = 32'h0000_000A;
      27: a = 32'h0000_0005;
      28: a = 32'h0000_0003;
      29: a = 32'h0000_0001;
      30: a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/core/sdf_twist_bend_point_warp_unit.sv @@
// ----------------------------------------------------------------------------
// sdf_twist_bend_point_warp_unit: twist/bend domain warp of a query point
// Rotates (px, py) about +z by rate_turns times pz (twist) or px (bend).
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries px_i, py_i, pz_i (Q16.16).
//   Output channel out_valid_o/out_ready_i carries qx_o, qy_o, qz_o.
//   Configuration channel cfg_valid_i/cfg_ready_o writes warp_mode (index 0)
//   or rate_turns (index 1); other indexes are ignored. cfg_ready_o is
//   always high; write only while no point is in flight.
//   A point passes two front-end stages (products, then rounding and
//   half-turn fold), one cell per CORDIC step, and the output register.
//   Throughput is one point per cycle while the receiver does not stall,
//   set by the fully pipelined cell chain.
//   Reset clears all stage valid bits and sets warp_mode and rate_turns to 0.
//   When the receiver stalls, the chain keeps filling empty stages and takes
//   new points until every stage holds one; in_ready_o then drops until the
//   result is taken. Results leave in input order.
// ----------------------------------------------------------------------------
module sdf_twist_bend_point_warp_unit #(
  parameter int CORDIC_STEPS = 24,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [sdftw_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sdftw_pkg::FIELD_W-1:0]          cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [sdftw_pkg::FIELD_W-1:0]   px_i,
  input  logic signed [sdftw_pkg::FIELD_W-1:0]   py_i,
  input  logic signed [sdftw_pkg::FIELD_W-1:0]   pz_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [sdftw_pkg::FIELD_W-1:0]   qx_o,
  output logic signed [sdftw_pkg::FIELD_W-1:0]   qy_o,
  output logic signed [sdftw_pkg::FIELD_W-1:0]   qz_o
);

  // Configuration registers
  logic                                 warp_mode_q;
  logic signed [sdftw_pkg::FIELD_W-1:0] rate_turns_q;

  // Links between the front end, the cells and the output stage
  logic             link_valid [CORDIC_STEPS+1];
  logic             link_ready [CORDIC_STEPS+1];
  sdftw_pkg::cell_t link_data  [CORDIC_STEPS+1];

  assign cfg_ready_o = 1'b1;

  // Take configuration writes; drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warp_mode_q  <= 1'b0;
      rate_turns_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sdftw_pkg::REG_WARP_MODE:  warp_mode_q  <= cfg_data_i[0];
        sdftw_pkg::REG_RATE_TURNS: rate_turns_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sdftw_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .warp_mode_i  (warp_mode_q),
    .rate_turns_i (rate_turns_q),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .px_i         (px_i),
    .py_i         (py_i),
    .pz_i         (pz_i),
    .valid_o      (link_valid[0]),
    .ready_i      (link_ready[0]),
    .data_o       (link_data[0])
  );

  // Chain of micro-rotation cells
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    sdftw_cordic_cell #(
      .STEP (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[g]),
      .ready_o (link_ready[g]),
      .data_i  (link_data[g]),
      .valid_o (link_valid[g+1]),
      .ready_i (link_ready[g+1]),
      .data_o  (link_data[g+1])
    );
  end

  sdftw_post #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (link_valid[CORDIC_STEPS]),
    .ready_o (link_ready[CORDIC_STEPS]),
    .data_i  (link_data[CORDIC_STEPS]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .qx_o    (qx_o),
    .qy_o    (qy_o),
    .qz_o    (qz_o)
  );

endmodule

@@ rtl/core/sdftw_prep.sv @@
// ----------------------------------------------------------------------------
// sdftw_prep: phase and gain front end
// Two stages: the rate, gain products, then rounding to Q.24 and the
// half-turn fold that brings the residual angle into [-1/4, 1/4) turn.
// ----------------------------------------------------------------------------
module sdftw_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                warp_mode_i,
  input  logic signed [sdftw_pkg::FIELD_W-1:0] rate_turns_i,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [sdftw_pkg::FIELD_W-1:0] px_i,
  input  logic signed [sdftw_pkg::FIELD_W-1:0] py_i,
  input  logic signed [sdftw_pkg::FIELD_W-1:0] pz_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output sdftw_pkg::cell_t                    data_o
);

  localparam int XY_W = sdftw_pkg::XY_W;
  localparam int Z_W  = sdftw_pkg::Z_W;
  localparam int FW   = sdftw_pkg::FIELD_W;
  localparam int PW   = 2 * FW;
  localparam logic signed [PW-1:0] ROUND = PW'(1) <<< (sdftw_pkg::PRE_SHIFT - 1);

  // Stage A registers: products
  logic              a_valid_q;
  logic [FW-1:0]     a_phase_q, a_phase_d;
  logic signed [PW-1:0] a_xprod_q, a_yprod_q;
  logic [FW-1:0]     a_pz_q;

  // Stage B register: first cell input
  logic              b_valid_q;
  sdftw_pkg::cell_t  b_data_q, b_data_d;

  logic              a_adv, b_adv;
  logic signed [FW-1:0] coord;
  logic signed [PW-1:0] rate_prod;
  logic signed [PW:0]   x_gain, y_gain;
  logic signed [PW-1:0] x_rnd, y_rnd, x_shr, y_shr;
  logic signed [XY_W-1:0] x_cut, y_cut;
  logic              fold;
  logic [FW-1:0]     phase_f;

  // Advance a stage when it is empty or its successor takes its transaction
  assign b_adv   = !b_valid_q || ready_i;
  assign a_adv   = !a_valid_q || b_adv;
  assign ready_o = a_adv;

  // Select the warp coordinate and form the phase and gain products
  assign coord     = warp_mode_i ? px_i : pz_i;
  assign rate_prod = rate_turns_i * coord;
  assign a_phase_d = rate_prod[sdftw_pkg::PHASE_LSB +: FW];
  assign x_gain    = px_i * $signed({1'b0, sdftw_pkg::GAIN_Q32});
  assign y_gain    = py_i * $signed({1'b0, sdftw_pkg::GAIN_Q32});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_q <= valid_i;
      end
      if (b_adv) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && valid_i) begin
      a_phase_q <= a_phase_d;
      a_xprod_q <= x_gain[PW-1:0];
      a_yprod_q <= y_gain[PW-1:0];
      a_pz_q    <= pz_i;
    end
    if (b_adv && a_valid_q) begin
      b_data_q <= b_data_d;
    end
  end

  // Round to Q.24 and fold phases in [1/4, 3/4) turn by a half turn
  assign x_rnd   = a_xprod_q + ROUND;
  assign y_rnd   = a_yprod_q + ROUND;
  assign x_shr   = x_rnd >>> sdftw_pkg::PRE_SHIFT;
  assign y_shr   = y_rnd >>> sdftw_pkg::PRE_SHIFT;
  assign x_cut   = x_shr[XY_W-1:0];
  assign y_cut   = y_shr[XY_W-1:0];
  assign fold    = a_phase_q[FW-1] ^ a_phase_q[FW-2];
  assign phase_f = {a_phase_q[FW-1] ^ fold, a_phase_q[FW-2:0]};

  always_comb begin
    b_data_d.x  = fold ? -x_cut : x_cut;
    b_data_d.y  = fold ? -y_cut : y_cut;
    b_data_d.z  = {{(Z_W-FW){phase_f[FW-1]}}, phase_f};
    b_data_d.pz = a_pz_q;
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_data_q;

endmodule

@@ rtl/core/sdftw_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// sdftw_cordic_cell: one CORDIC micro-rotation
// Rotates by plus or minus atan(2^-STEP) toward a zero residual angle and
// registers the point for the next cell.
// ----------------------------------------------------------------------------
module sdftw_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  sdftw_pkg::cell_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output sdftw_pkg::cell_t data_o
);

  localparam int Z_W = sdftw_pkg::Z_W;
  localparam logic [Z_W-1:0] ANGLE =
    {{(Z_W-32){1'b0}}, sdftw_pkg::atan_turns(STEP)};

  logic             valid_q;
  sdftw_pkg::cell_t data_q, data_d;
  logic             adv;
  logic signed [sdftw_pkg::XY_W-1:0] dx, dy;

  // Advance when empty or when the next cell takes the transaction
  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  // Rotate toward zero residual angle
  assign dx = data_i.y >>> STEP;
  assign dy = data_i.x >>> STEP;

  always_comb begin
    data_d.pz = data_i.pz;
    if (!data_i.z[Z_W-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - $signed(ANGLE);
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + $signed(ANGLE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/core/sdftw_post.sv @@
// ----------------------------------------------------------------------------
// sdftw_post: output rounding and saturation
// Drops the guard bits with round half up, clamps to the coordinate range
// and holds the result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module sdftw_post #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  sdftw_pkg::cell_t                     data_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [sdftw_pkg::FIELD_W-1:0] qx_o,
  output logic signed [sdftw_pkg::FIELD_W-1:0] qy_o,
  output logic signed [sdftw_pkg::FIELD_W-1:0] qz_o
);

  localparam int XY_W  = sdftw_pkg::XY_W;
  localparam int FW    = sdftw_pkg::FIELD_W;
  localparam int SAT_W = (COORD_WIDTH < FW) ? COORD_WIDTH : FW;
  localparam logic signed [XY_W-1:0] HALF = XY_W'(1) <<< (sdftw_pkg::GUARD_BITS - 1);
  localparam logic signed [XY_W-1:0] HI   =
    {{(XY_W-SAT_W+1){1'b0}}, {(SAT_W-1){1'b1}}};
  localparam logic signed [XY_W-1:0] LO   = ~HI;

  logic                 valid_q;
  logic signed [FW-1:0] qx_q, qy_q, qz_q, qx_d, qy_d;
  logic                 adv;
  logic signed [XY_W-1:0] x_r, y_r, x_c, y_c;

  // Accept while empty or while the held result is being taken
  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  // Round off the guard bits
  assign x_r = (data_i.x + HALF) >>> sdftw_pkg::GUARD_BITS;
  assign y_r = (data_i.y + HALF) >>> sdftw_pkg::GUARD_BITS;

  // Clamp to the signed coordinate range
  assign x_c  = (x_r > HI) ? HI : ((x_r < LO) ? LO : x_r);
  assign y_c  = (y_r > HI) ? HI : ((y_r < LO) ? LO : y_r);
  assign qx_d = x_c[FW-1:0];
  assign qy_d = y_c[FW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      qx_q <= qx_d;
      qy_q <= qy_d;
      qz_q <= data_i.pz;
    end
  end

  assign valid_o = valid_q;
  assign qx_o    = qx_q;
  assign qy_o    = qy_q;
  assign qz_o    = qz_q;

endmodule

@@ rtl/core/sdftw_checker.sv @@
// ----------------------------------------------------------------------------
// sdftw_checker: port-level checks for the point warp unit
// Watches the handshakes of the top level and flags flow-control slips.
// ----------------------------------------------------------------------------
module sdftw_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 cfg_ready_o,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [sdftw_pkg::FIELD_W-1:0] qx_o,
  input logic signed [sdftw_pkg::FIELD_W-1:0] qy_o,
  input logic signed [sdftw_pkg::FIELD_W-1:0] qz_o
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(qx_o) &&
      $stable(qy_o) && $stable(qz_o))
    else $error("stalled result changed or dropped");

  // Back-pressure only when the whole chain is full
  a_full_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // A full chain stays full while the receiver stalls
  a_full_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_ready_i |=> !in_ready_o)
    else $error("input reopened without a result taken");

  // Configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port stalled");

endmodule

bind sdf_twist_bend_point_warp_unit sdftw_checker u_sdftw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready_o (cfg_ready_o),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .qx_o        (qx_o),
  .qy_o        (qy_o),
  .qz_o        (qz_o)
);
